// ----- rtl/jslu_pkg.sv -----
`timescale 1ns / 1ps

package jslu_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_STR  = 4'b0010,
    MODE_ESC  = 4'b0100,
    MODE_HEX  = 4'b1000
  } mode_e;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_DATA   = 3'd1,
    ST_END_OK = 3'd2,
    ST_END_ER = 3'd3,
    ST_NOOPEN = 3'd4
  } status_e;

  // decoder state; hex_value holds the first three digits only
  typedef struct packed {
    mode_e       mode;
    logic [1:0]  hex_digits_seen;
    logic [11:0] hex_value;
    logic        failed;
  } dec_state_t;

  localparam dec_state_t StateReset = '{
    mode:            MODE_IDLE,
    hex_digits_seen: 2'd0,
    hex_value:       12'd0,
    failed:          1'b0
  };

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChN = 8'h6E;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChU = 8'h75;

endpackage

// ----- rtl/jslu_step.sv -----
`timescale 1ns / 1ps

module jslu_step (
  input  jslu_pkg::dec_state_t state_i,
  input  logic [7:0]           text_byte_i,
  output jslu_pkg::dec_state_t state_o,
  output logic [7:0]           out_byte_o,
  output jslu_pkg::status_e    status_o
);

  logic        nib_ok;
  logic [3:0]  nib;
  logic [15:0] full_value;

  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'd0;
    if (text_byte_i >= 8'h30 && text_byte_i <= 8'h39) begin
      nib = text_byte_i[3:0];
    end else if ((text_byte_i >= 8'h61 && text_byte_i <= 8'h66) ||
                 (text_byte_i >= 8'h41 && text_byte_i <= 8'h46)) begin
      nib = text_byte_i[3:0] + 4'd9;
    end else begin
      nib_ok = 1'b0;
    end
  end

  assign full_value = {state_i.hex_value, nib};

  always_comb begin
    state_o    = state_i;
    out_byte_o = 8'd0;
    status_o   = jslu_pkg::ST_NONE;
    unique case (state_i.mode)
      jslu_pkg::MODE_IDLE: begin
        if (text_byte_i == jslu_pkg::ChQuote) begin
          state_o.mode = jslu_pkg::MODE_STR;
        end else begin
          status_o = jslu_pkg::ST_NOOPEN;
        end
      end
      jslu_pkg::MODE_STR: begin
        if (text_byte_i == jslu_pkg::ChQuote) begin
          status_o = state_i.failed ? jslu_pkg::ST_END_ER : jslu_pkg::ST_END_OK;
          state_o  = jslu_pkg::StateReset;
        end else if (text_byte_i == jslu_pkg::ChBslash) begin
          state_o.mode = jslu_pkg::MODE_ESC;
        end else if (!state_i.failed) begin
          status_o   = jslu_pkg::ST_DATA;
          out_byte_o = text_byte_i;
        end
      end
      jslu_pkg::MODE_ESC: begin
        state_o.mode = jslu_pkg::MODE_STR;
        // after a failure the letter is only consumed to keep pairing
        if (!state_i.failed) begin
          status_o = jslu_pkg::ST_DATA;
          case (text_byte_i)
            jslu_pkg::ChQuote:  out_byte_o = jslu_pkg::ChQuote;
            jslu_pkg::ChBslash: out_byte_o = jslu_pkg::ChBslash;
            jslu_pkg::ChSlash:  out_byte_o = jslu_pkg::ChSlash;
            jslu_pkg::ChB:      out_byte_o = 8'h08;
            jslu_pkg::ChF:      out_byte_o = 8'h0C;
            jslu_pkg::ChN:      out_byte_o = 8'h0A;
            jslu_pkg::ChR:      out_byte_o = 8'h0D;
            jslu_pkg::ChT:      out_byte_o = 8'h09;
            jslu_pkg::ChU: begin
              status_o                = jslu_pkg::ST_NONE;
              state_o.mode            = jslu_pkg::MODE_HEX;
              state_o.hex_digits_seen = 2'd0;
              state_o.hex_value       = 12'd0;
            end
            default: begin
              status_o       = jslu_pkg::ST_NONE;
              state_o.failed = 1'b1;
            end
          endcase
        end
      end
      jslu_pkg::MODE_HEX: begin
        if (text_byte_i == jslu_pkg::ChQuote) begin
          status_o = jslu_pkg::ST_END_ER;
          state_o  = jslu_pkg::StateReset;
        end else if (!nib_ok) begin
          state_o.failed          = 1'b1;
          state_o.mode            = (text_byte_i == jslu_pkg::ChBslash) ?
                                    jslu_pkg::MODE_ESC : jslu_pkg::MODE_STR;
          state_o.hex_digits_seen = 2'd0;
          state_o.hex_value       = 12'd0;
        end else if (state_i.hex_digits_seen == 2'd3) begin
          if (full_value[15:8] != 8'd0) begin
            state_o.failed = 1'b1;
          end else begin
            status_o   = jslu_pkg::ST_DATA;
            out_byte_o = full_value[7:0];
          end
          state_o.mode            = jslu_pkg::MODE_STR;
          state_o.hex_digits_seen = 2'd0;
          state_o.hex_value       = 12'd0;
        end else begin
          state_o.hex_value       = full_value[11:0];
          state_o.hex_digits_seen = state_i.hex_digits_seen + 2'd1;
        end
      end
      default: begin
        state_o = jslu_pkg::StateReset;
      end
    endcase
  end

endmodule

// ----- rtl/json_string_literal_unescaper_top.sv -----
`timescale 1ns / 1ps

// JSON string literal unescaper.
// Input channel: text_byte_i with in_valid_i / in_stall_o carries one raw
// text word per handshake, the opening quote first.
// Output channel: out_byte_o and status_o with out_valid_o / out_stall_i
// carry exactly one result word per input word (status 0 nothing, 1 data,
// 2 end ok, 3 end with error, 4 missing opening quote).
// Path: a taken word enters the input register, then the decode step writes
// the result register, which drives out_valid_o; one input register, then the
// decode step into the result register.
// Throughput is one word per cycle while the receiver does not stall; the
// decoder state register updates on every step, so consecutive words flow without gaps.
// When the receiver stalls, the result register holds its word; an empty input
// register can still take one word, and in_stall_o is high while it holds one.
// On a status 3 end the consumer drops the data bytes of that literal.
// Reset (rst_ni low) empties both registers and returns the decoder to
// idle, waiting for an opening quote.
module json_string_literal_unescaper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o
);

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 out_valid_q;
  logic [7:0]           out_byte_q, out_byte_d;
  jslu_pkg::status_e    status_q, status_d;
  jslu_pkg::dec_state_t state_q, state_d;
  logic                 out_free;
  logic                 step_en;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_en    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  jslu_step u_step (
    .state_i     (state_q),
    .text_byte_i (in_byte_q),
    .state_o     (state_d),
    .out_byte_o  (out_byte_d),
    .status_o    (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= jslu_pkg::StateReset;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= step_en;
      end
      if (step_en) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= text_byte_i;
    end
    if (step_en) begin
      out_byte_q <= out_byte_d;
      status_q   <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = status_q;

endmodule

// ----- verif/jslu_checker.sv -----
`timescale 1ns / 1ps

module jslu_checker
  import jslu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] text_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic [2:0] status_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlTab = 8'h09;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlCr  = 8'h0D;
  localparam logic [15:0] CodeMax = 16'h00FF;

  typedef struct packed {
    logic [7:0] data;
    status_e    st;
  } dec_word_t;

  // decoder copy
  mode_e       dec_mode;
  logic [1:0]  hex_count;
  logic [15:0] hex_acc;
  logic        lit_bad;

  dec_word_t expected_q[$];
  dec_word_t exp_w;
  dec_word_t pred_w;
  int        fails;

  function automatic void restart_decoder();
    dec_mode  = MODE_IDLE;
    hex_count = 2'd0;
    hex_acc   = 16'd0;
    lit_bad   = 1'b0;
  endfunction

  function automatic int hex_digit_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic dec_word_t decode_word(logic [7:0] b);
    dec_word_t r;
    int        nib;
    r.data = 8'h00;
    r.st   = ST_NONE;
    case (dec_mode)
      MODE_IDLE: begin
        if (b == ChQuote) dec_mode = MODE_STR;
        else r.st = ST_NOOPEN;
      end
      MODE_STR: begin
        if (b == ChQuote) begin
          r.st = lit_bad ? ST_END_ER : ST_END_OK;
          restart_decoder();
        end else if (b == ChBslash) begin
          dec_mode = MODE_ESC;
        end else if (!lit_bad) begin
          r.st   = ST_DATA;
          r.data = b;
        end
      end
      MODE_ESC: begin
        dec_mode = MODE_STR;
        // a failed literal still consumes the escaped word, emits nothing
        if (!lit_bad) begin
          r.st = ST_DATA;
          case (b)
            ChQuote, ChBslash, ChSlash: r.data = b;
            ChB: r.data = CtlBs;
            ChF: r.data = CtlFf;
            ChN: r.data = CtlLf;
            ChR: r.data = CtlCr;
            ChT: r.data = CtlTab;
            ChU: begin
              r.st      = ST_NONE;
              dec_mode  = MODE_HEX;
              hex_count = 2'd0;
              hex_acc   = 16'd0;
            end
            default: begin
              r.st    = ST_NONE;
              lit_bad = 1'b1;
            end
          endcase
        end
      end
      MODE_HEX: begin
        nib = hex_digit_value(b);
        if (b == ChQuote) begin
          r.st = ST_END_ER;
          restart_decoder();
        end else if (nib < 0) begin
          lit_bad   = 1'b1;
          dec_mode  = (b == ChBslash) ? MODE_ESC : MODE_STR;
          hex_count = 2'd0;
          hex_acc   = 16'd0;
        end else begin
          hex_acc = {hex_acc[11:0], nib[3:0]};
          if (hex_count == 2'd3) begin
            if (hex_acc > CodeMax) begin
              lit_bad = 1'b1;
            end else begin
              r.st   = ST_DATA;
              r.data = hex_acc[7:0];
            end
            dec_mode  = MODE_STR;
            hex_count = 2'd0;
            hex_acc   = 16'd0;
          end else begin
            hex_count = hex_count + 2'd1;
          end
        end
      end
      default: restart_decoder();
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_decoder();
      expected_q.delete();
      fails        = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // retire first: a result word never belongs to a word taken this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word: out_byte 8'h%02h status %0d", out_byte_i, status_i);
          fails++;
        end else begin
          exp_w = expected_q.pop_front();
          if (out_byte_i !== exp_w.data) begin
            $error("out_byte: expected 8'h%02h, got 8'h%02h", exp_w.data, out_byte_i);
            fails++;
          end
          if (status_i !== exp_w.st) begin
            $error("status: expected %0d, got %0d", exp_w.st, status_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pred_w = decode_word(text_byte_i);
        expected_q.push_back(pred_w);
      end
      fail_count_o = fails;
      pending_o    = expected_q.size();
    end
  end

endmodule

// ----- verif/tb_json_string_literal_unescaper_top.sv -----
`timescale 1ns / 1ps

module tb_json_string_literal_unescaper_top;
  import jslu_pkg::*;

  localparam int HoldCycles = 200;
  localparam int QuietLimit = 2000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] text_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [2:0] status;

  int         fail_count;
  int         pending;
  int         words_sent;
  int         quiet_cycles;
  bit         tx_idle_on;
  bit         rx_idle_on;
  bit         hold_req;

  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  json_string_literal_unescaper_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .text_byte_i (text_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_byte_o  (out_byte),
    .status_o    (status)
  );

  jslu_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .text_byte_i  (text_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .status_i     (status),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic bit is_hex_char(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic bit is_escape_letter(logic [7:0] b);
    return b inside {ChQuote, ChBslash, ChSlash, ChB, ChF, ChN, ChR, ChT, ChU};
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    if (nib < 4'd10) return "0" + 8'(nib);
    if ($urandom_range(0, 1) == 0) return "a" + 8'(nib - 4'd10);
    return "A" + 8'(nib - 4'd10);
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(logic [7:0] b);
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      in_valid  <= 1'b0;
      text_byte <= 8'($urandom);
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    do @(posedge clk_i); while (in_stall);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_hex(logic [15:0] v, int ndig);
    for (int i = 3; i > 3 - ndig; i--) send_word(hex_char(v[i*4 +: 4]));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  task automatic send_literal();
    int         nseg;
    int         k;
    bit         closed;
    logic [7:0] b;
    logic [7:0] letters [8];
    letters = '{ChQuote, ChBslash, ChSlash, ChB, ChF, ChN, ChR, ChT};
    closed  = 1'b0;
    nseg    = $urandom_range(0, 8);
    send_word(ChQuote);
    for (int s = 0; s < nseg && !closed; s++) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        do b = 8'($urandom_range(0, 255)); while (b == ChQuote || b == ChBslash);
        send_word(b);
      end else if (k < 75) begin
        send_word(ChBslash);
        send_word(letters[$urandom_range(0, 7)]);
      end else if (k < 90) begin
        send_word(ChBslash);
        send_word(ChU);
        send_hex({8'h00, 8'($urandom_range(0, 255))}, 4);
      end else if (k < 93) begin
        // unknown escape letter
        do b = 8'($urandom_range(0, 255)); while (is_escape_letter(b));
        send_word(ChBslash);
        send_word(b);
      end else if (k < 95) begin
        send_word(ChBslash);
        send_word(ChU);
        send_hex(16'($urandom_range(16'h0100, 16'hFFFF)), 4);
      end else if (k < 98) begin
        // bad digit after zero to three good ones; a backslash opens a new pair
        send_word(ChBslash);
        send_word(ChU);
        send_hex(16'($urandom), $urandom_range(0, 3));
        if ($urandom_range(0, 1) == 0) begin
          send_word(ChBslash);
          send_word(letters[$urandom_range(2, 7)]);
        end else begin
          do b = 8'($urandom_range(0, 255));
          while (is_hex_char(b) || b == ChQuote || b == ChBslash);
          send_word(b);
        end
      end else begin
        // quote among the hex digits closes the literal
        send_word(ChBslash);
        send_word(ChU);
        send_hex(16'($urandom), $urandom_range(0, 3));
        send_word(ChQuote);
        closed = 1'b1;
      end
    end
    if (!closed) send_word(ChQuote);
  endtask

  task automatic send_random();
    if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(0, 255)));
    else send_literal();
  endtask

  initial begin
    logic [7:0] dir_q[$];
    in_valid   = 1'b0;
    text_byte  = 8'h00;
    rst_ni     = 1'b0;
    words_sent = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req   = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    dir_q = {
      8'hFF,
      // plain extremes, all simple escapes, \u with mixed case
      ChQuote, 8'h00, 8'hFF, ChBslash, ChQuote, ChBslash, ChBslash, ChBslash, ChSlash,
      ChBslash, ChB, ChBslash, ChF, ChBslash, ChN, ChBslash, ChR, ChBslash, ChT,
      ChBslash, ChU, "0", "0", "f", "F", ChQuote,
      // unknown escape, then escaped quote must not close
      ChQuote, ChBslash, "q", "a", ChBslash, ChQuote, ChQuote,
      // code above 0xFF
      ChQuote, ChBslash, ChU, "0", "1", "0", "0", ChQuote,
      // backslash among the digits
      ChQuote, ChBslash, ChU, "1", ChBslash, ChN, ChQuote,
      // plain non-hex among the digits
      ChQuote, ChBslash, ChU, "A", "z", ChQuote,
      // quote among the digits
      ChQuote, ChBslash, ChU, "1", "2", ChQuote
    };
    foreach (dir_q[i]) send_word(dir_q[i]);

    while (words_sent < 300) send_random();
    drain();

    hold_req = 1'b1;
    while (words_sent < 500) send_random();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (words_sent < 640) send_random();

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- json_string_literal_unescaper_top.f -----
rtl/jslu_pkg.sv
rtl/jslu_step.sv
rtl/json_string_literal_unescaper_top.sv
verif/jslu_checker.sv
verif/tb_json_string_literal_unescaper_top.sv
